[sv/rtp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg
// shared types, codes and constants of the repeating timer pool
// ----------------------------------------------------------------------------
package rtp_pkg;

   localparam int DEFAULT_NUM_TIMERS = 10;

   localparam int DELAY_W = 16;
   localparam int TAG_W   = 16;
   localparam int REPS_W  = 8;
   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 4;

   // request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;

   // one slot entry of the timer store
   typedef struct packed {
      logic [DELAY_W-1:0] ticks;
      logic [DELAY_W-1:0] interval;
      logic [TAG_W-1:0]   tag;
      logic [REPS_W-1:0]  reps;
   } slot_entry_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;     // latch request fields
      logic idx_clear;
      logic idx_inc;
      logic mem_read;     // fetch entry at current index
      logic start_write;  // load free slot, push accept result
      logic push_reject;
      logic commit;       // write back counted entry, stage any expiry
      logic flush;        // push staged expiry as final result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cur_active;
      logic idx_last;
      logic expire;
      logic hold_valid;
      logic out_free;
   } dp_status_type;

endpackage

[sv/rtp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_ctrl
// sequencer for start scans and tick sweeps over the timer slots
// ----------------------------------------------------------------------------
module rtp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_stall,
   input  rtp_pkg::dp_status_type status,
   output rtp_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_ACPT  = 3'd2;
   localparam logic [2:0] ST_REJ   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_PROC  = 3'd5;
   localparam logic [2:0] ST_FLUSH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req  = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in = (req_opcode == rtp_pkg::OP_START) ? ST_SCAN : ST_READ;
            end
         end
         ST_SCAN: begin
            if (!status.cur_active) begin
               state_in = ST_ACPT;
            end else if (status.idx_last) begin
               state_in = ST_REJ;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_ACPT: begin
            if (status.out_free) begin
               cmd.start_write = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REJ: begin
            if (status.out_free) begin
               cmd.push_reject = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (status.cur_active) begin
               cmd.mem_read = 1'b1;
               state_in = ST_PROC;
            end else if (status.idx_last) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_PROC: begin
            // a new expiry pushes the staged one out, so wait for room
            if (!status.expire || !status.hold_valid || status.out_free) begin
               cmd.commit = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.hold_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/rtp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_datapath
// slot store, busy bits, slot index, staged expiry and result register
// ----------------------------------------------------------------------------
module rtp_datapath #(
   parameter int NUM_TIMERS = rtp_pkg::DEFAULT_NUM_TIMERS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rtp_pkg::dp_cmd_type             cmd,
   output rtp_pkg::dp_status_type          status,
   input  logic [rtp_pkg::DELAY_W-1:0]     req_delay,
   input  logic [rtp_pkg::TAG_W-1:0]       req_tag,
   input  logic [rtp_pkg::REPS_W-1:0]      req_repeat_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rtp_pkg::KIND_W-1:0]      rsp_kind,
   output logic [rtp_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [rtp_pkg::TAG_W-1:0]       rsp_tag_out,
   output logic [rtp_pkg::REPS_W-1:0]      rsp_repeats_left,
   output logic                            rsp_last
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(NUM_TIMERS - 1);

   // slot store
   rtp_pkg::slot_entry_type mem [NUM_TIMERS];
   rtp_pkg::slot_entry_type rd_ff;

   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   logic [rtp_pkg::DELAY_W-1:0] delay_ff;
   logic [rtp_pkg::TAG_W-1:0]   tag_ff;
   logic [rtp_pkg::REPS_W-1:0]  reps_ff;

   // staged expiry
   logic                        hold_valid_ff, hold_valid_in;
   logic [rtp_pkg::SLOT_W-1:0]  hold_slot_ff;
   logic [rtp_pkg::TAG_W-1:0]   hold_tag_ff;
   logic [rtp_pkg::REPS_W-1:0]  hold_reps_ff;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic [rtp_pkg::KIND_W-1:0]  out_kind_ff, out_kind_in;
   logic [rtp_pkg::SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [rtp_pkg::TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic [rtp_pkg::REPS_W-1:0]  out_reps_ff, out_reps_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_load;

   logic [IDX_W+rtp_pkg::SLOT_W-1:0] idx_ext;
   logic [rtp_pkg::SLOT_W-1:0]       cur_slot;

   logic [rtp_pkg::DELAY_W-1:0] ticks_dec;
   logic [rtp_pkg::REPS_W-1:0]  reps_dec;
   logic                        expire;
   logic                        release_slot;
   rtp_pkg::slot_entry_type     wr_entry;
   rtp_pkg::slot_entry_type     start_entry;

   assign idx_ext  = {{rtp_pkg::SLOT_W{1'b0}}, idx_ff};
   assign cur_slot = idx_ext[rtp_pkg::SLOT_W-1:0];

   // countdown of the fetched entry
   always_comb begin
      ticks_dec    = (rd_ff.ticks != '0) ? rd_ff.ticks - 1'b1 : '0;
      reps_dec     = (rd_ff.reps != '0) ? rd_ff.reps - 1'b1 : '0;
      expire       = (ticks_dec == '0);
      release_slot = expire && (reps_dec == '0);
      wr_entry          = rd_ff;
      wr_entry.ticks    = expire ? rd_ff.interval : ticks_dec;
      wr_entry.reps     = expire ? reps_dec : rd_ff.reps;
      start_entry.ticks    = delay_ff;
      start_entry.interval = delay_ff;
      start_entry.tag      = tag_ff;
      start_entry.reps     = reps_ff;
   end

   assign status.cur_active = active_ff[idx_ff];
   assign status.idx_last   = (idx_ff == IDX_MAX);
   assign status.expire     = expire;
   assign status.hold_valid = hold_valid_ff;
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      active_in = active_ff;
      if (cmd.start_write) begin
         active_in[idx_ff] = 1'b1;
      end else if (cmd.commit && release_slot) begin
         active_in[idx_ff] = 1'b0;
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (cmd.commit && expire) begin
         hold_valid_in = 1'b1;
      end else if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_load    = 1'b1;
      out_kind_in = out_kind_ff;
      out_slot_in = out_slot_ff;
      out_tag_in  = out_tag_ff;
      out_reps_in = out_reps_ff;
      out_last_in = out_last_ff;
      priority if (cmd.start_write) begin
         out_kind_in = rtp_pkg::KIND_ACCEPT;
         out_slot_in = cur_slot;
         out_tag_in  = '0;
         out_reps_in = '0;
         out_last_in = 1'b1;
      end else if (cmd.push_reject) begin
         out_kind_in = rtp_pkg::KIND_REJECT;
         out_slot_in = '0;
         out_tag_in  = '0;
         out_reps_in = '0;
         out_last_in = 1'b1;
      end else if ((cmd.commit && expire && hold_valid_ff) || cmd.flush) begin
         out_kind_in = rtp_pkg::KIND_EXPIRY;
         out_slot_in = hold_slot_ff;
         out_tag_in  = hold_tag_ff;
         out_reps_in = hold_reps_ff;
         out_last_in = cmd.flush;
      end else begin
         out_load = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // slot store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.start_write) begin
         mem[idx_ff] <= start_entry;
      end else if (cmd.commit) begin
         mem[idx_ff] <= wr_entry;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      out_kind_ff <= out_kind_in;
      out_slot_ff <= out_slot_in;
      out_tag_ff  <= out_tag_in;
      out_reps_ff <= out_reps_in;
      out_last_ff <= out_last_in;
      if (cmd.take_req) begin
         delay_ff <= req_delay;
         tag_ff   <= req_tag;
         reps_ff  <= req_repeat_count;
      end
      if (cmd.commit && expire) begin
         hold_slot_ff <= cur_slot;
         hold_tag_ff  <= rd_ff.tag;
         hold_reps_ff <= reps_dec;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_tag_out      = out_tag_ff;
   assign rsp_repeats_left = out_reps_ff;
   assign rsp_last         = out_last_ff;

endmodule

[sv/repeating_timer_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_timer_pool
// pool of countdown timers with one-shot and repeating modes
// ----------------------------------------------------------------------------
// usage
//   request channel (req_*): opcode start loads the lowest free slot with
//   delay, tag and repeat count; opcode tick counts every busy slot down
//   result channel (rsp_*): one accept or reject item per start, and one
//   expiry item per slot that runs out on a tick, in slot order; rsp_last
//   marks the final item of a request, a tick with no expiry gives none
// request handling
//   one request at a time; req_stall stays high until the request is done
//   start: scans busy bits one slot a cycle, from slot 0 up to the first free one
//   tick: visits every slot in order; a busy slot is read from the store,
//   then counted and written back, and a final flush step ends the sweep
// reset
//   synchronous; every slot is free and the result register is empty
// back-pressure
//   a result waits in the output register while rsp_stall is high; a tick
//   sweep pauses when a second expiry is ready and the stalled register is full
// ----------------------------------------------------------------------------
module repeating_timer_pool #(
   parameter int NUM_TIMERS = rtp_pkg::DEFAULT_NUM_TIMERS
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [rtp_pkg::DELAY_W-1:0] req_delay,
   input  logic [rtp_pkg::TAG_W-1:0]   req_tag,
   input  logic [rtp_pkg::REPS_W-1:0]  req_repeat_count,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rtp_pkg::KIND_W-1:0]  rsp_kind,
   output logic [rtp_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [rtp_pkg::TAG_W-1:0]   rsp_tag_out,
   output logic [rtp_pkg::REPS_W-1:0]  rsp_repeats_left,
   output logic                        rsp_last
);

   // command and status between sequencer and datapath
   rtp_pkg::dp_cmd_type    cmd;
   rtp_pkg::dp_status_type status;

   // sequencer: start scan, tick sweep, final flush of staged expiry
   rtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // slot store, busy bits and result register
   rtp_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_delay        (req_delay),
      .req_tag          (req_tag),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_repeats_left (rsp_repeats_left),
      .rsp_last         (rsp_last)
   );

endmodule

[tb/tb_repeating_timer_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeating_timer_pool
// self-checking bench for the repeating timer pool
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a clocked driver; every accepted request
// runs through a local model of the pool, and the events it predicts are
// checked field by field against the result channel in arrival order. a
// short directed sequence covers the corner cases, then random starts and
// ticks follow, with random gaps on both sides, one long result hold-off
// and one full drain
// ----------------------------------------------------------------------------
module tb_repeating_timer_pool;

   localparam int NUM_TIMERS    = rtp_pkg::DEFAULT_NUM_TIMERS;
   localparam int DELAY_W       = rtp_pkg::DELAY_W;
   localparam int TAG_W         = rtp_pkg::TAG_W;
   localparam int REPS_W        = rtp_pkg::REPS_W;
   localparam int KIND_W        = rtp_pkg::KIND_W;
   localparam int SLOT_W        = rtp_pkg::SLOT_W;
   localparam int RANDOM_ITEMS  = 330;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;

   // one request as offered on the req_ channel
   typedef struct {
      logic               opcode;
      logic [DELAY_W-1:0] delay;
      logic [TAG_W-1:0]   tag;
      logic [REPS_W-1:0]  reps;
   } timer_req_type;

   // one result as seen on the rsp_ channel
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic [REPS_W-1:0] reps;
      logic              last;
   } timer_event_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_opcode;
   logic [DELAY_W-1:0]  req_delay;
   logic [TAG_W-1:0]    req_tag;
   logic [REPS_W-1:0]   req_repeat_count;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic [REPS_W-1:0]   rsp_repeats_left;
   logic                rsp_last;

   repeating_timer_pool #(
      .NUM_TIMERS(NUM_TIMERS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_delay        (req_delay),
      .req_tag          (req_tag),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_repeats_left (rsp_repeats_left),
      .rsp_last         (rsp_last)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // model copy of the timer store
   bit                slot_busy    [NUM_TIMERS];
   bit [DELAY_W-1:0]  slot_count   [NUM_TIMERS];
   bit [DELAY_W-1:0]  slot_period  [NUM_TIMERS];
   bit [TAG_W-1:0]    slot_label   [NUM_TIMERS];
   bit [REPS_W-1:0]   slot_reps    [NUM_TIMERS];

   timer_req_type   pending_reqs[$];     // requests not yet offered
   timer_event_type expected_events[$];  // predicted results still to arrive

   bit  item_taken;      // set at the edge where the current item went in
   bit  quiet;           // window with no random gaps on either side
   bit  hold_done;
   int  hold_left;
   int  items_queued;
   int  items_accepted;
   int  errors;
   int  cycle_count;
   int  starts_seen, ticks_seen;
   int  accepts_seen, rejects_seen, expiries_seen;

   // ------------------------------------------------------------------------
   // pool model: updates the local store and appends the results a request
   // should produce
   // ------------------------------------------------------------------------
   task automatic apply_timer_request(input timer_req_type r);
      timer_event_type ev;
      timer_event_type fired[$];
      bit              placed;
      placed = 1'b0;
      if (r.opcode == rtp_pkg::OP_START) begin
         starts_seen++;
         // lowest free slot wins, otherwise a reject with slot 0
         ev = '{kind: rtp_pkg::KIND_REJECT, slot: '0, tag: '0, reps: '0, last: 1'b1};
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!placed && !slot_busy[i]) begin
               placed         = 1'b1;
               slot_busy[i]   = 1'b1;
               slot_count[i]  = r.delay;
               slot_period[i] = r.delay;
               slot_label[i]  = r.tag;
               slot_reps[i]   = r.reps;
               ev.kind        = rtp_pkg::KIND_ACCEPT;
               ev.slot        = i[SLOT_W-1:0];
            end
         end
         if (placed)
            accepts_seen++;
         else
            rejects_seen++;
         expected_events.push_back(ev);
      end else begin
         ticks_seen++;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (slot_busy[i]) begin
               // saturating countdown, fires once it sits at zero
               if (slot_count[i] != 0)
                  slot_count[i]--;
               if (slot_count[i] == 0) begin
                  if (slot_reps[i] != 0) begin
                     slot_reps[i]--;
                     if (slot_reps[i] == 0)
                        slot_busy[i] = 1'b0;
                     else
                        slot_count[i] = slot_period[i];
                  end else begin
                     slot_busy[i] = 1'b0;
                  end
                  ev = '{kind: rtp_pkg::KIND_EXPIRY, slot: i[SLOT_W-1:0],
                         tag: slot_label[i], reps: slot_reps[i], last: 1'b0};
                  fired.push_back(ev);
               end
            end
         end
         // a tick with nothing expiring gives no result at all
         if (fired.size() > 0)
            fired[fired.size()-1].last = 1'b1;
         foreach (fired[k])
            expected_events.push_back(fired[k]);
         expiries_seen += fired.size();
      end
   endtask

   task automatic queue_req(input logic op, input logic [DELAY_W-1:0] delay,
                            input logic [TAG_W-1:0] tag, input logic [REPS_W-1:0] reps);
      timer_req_type r;
      r = '{opcode: op, delay: delay, tag: tag, reps: reps};
      pending_reqs.push_back(r);
      items_queued++;
   endtask

   // ------------------------------------------------------------------------
   // request driver: changes inputs on the falling edge, holds the payload
   // while the block stalls, and leaves random gaps between items
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      timer_req_type nxt;
      if (!reset) begin
         if (!req_valid || item_taken) begin
            item_taken = 1'b0;
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
               nxt = pending_reqs.pop_front();
               req_opcode       <= nxt.opcode;
               req_delay        <= nxt.delay;
               req_tag          <= nxt.tag;
               req_repeat_count <= nxt.reps;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result back-pressure: random stalls, plus one long hold-off counted
   // here so the block fills up and stalls its request side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= 60) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: takes requests and results on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      timer_req_type   got_req;
      timer_event_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            got_req = '{opcode: req_opcode, delay: req_delay, tag: req_tag,
                        reps: req_repeat_count};
            apply_timer_request(got_req);
            item_taken = 1'b1;
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected item kind %0d slot %0d tag %h reps %0d last %0b",
                           $realtime, rsp_kind, rsp_slot, rsp_tag_out, rsp_repeats_left,
                           rsp_last);
            end else begin
               want = expected_events.pop_front();
               if (rsp_kind !== want.kind || rsp_slot !== want.slot ||
                   rsp_tag_out !== want.tag || rsp_repeats_left !== want.reps ||
                   rsp_last !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     $write("%0t: mismatch (expected/actual) kind %0d/%0d slot %0d/%0d",
                            $realtime, want.kind, rsp_kind, want.slot, rsp_slot);
                     $display(" tag %h/%h reps %0d/%0d last %0b/%0b",
                              want.tag, rsp_tag_out, want.reps, rsp_repeats_left,
                              want.last, rsp_last);
                  end
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still expected",
                  cycle_count, expected_events.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      timer_req_type r;
      int            roll;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = rtp_pkg::OP_TICK;
      req_delay        = '0;
      req_tag          = '0;
      req_repeat_count = '0;
      rsp_stall        = 1'b0;
      item_taken       = 1'b0;
      quiet            = 1'b0;
      hold_done        = 1'b0;
      hold_left        = 0;
      foreach (slot_busy[i])
         slot_busy[i] = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-pool tick with junk fields, which must be ignored
      queue_req(rtp_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
      // one-shots at delay 0 and 1, a repeating and a single-repeat timer,
      // one that never runs out and one more repeater
      queue_req(rtp_pkg::OP_START, 16'd0, 16'h0000, 8'd0);
      queue_req(rtp_pkg::OP_START, 16'd1, 16'hFFFF, 8'd0);
      queue_req(rtp_pkg::OP_START, 16'd1, 16'h1234, 8'd3);
      queue_req(rtp_pkg::OP_START, 16'd2, 16'hABCD, 8'd1);
      queue_req(rtp_pkg::OP_START, 16'hFFFF, 16'h5A5A, 8'hFF);
      queue_req(rtp_pkg::OP_START, 16'd3, 16'hA5A5, 8'd2);
      queue_req(rtp_pkg::OP_TICK, 16'd0, 16'd0, 8'd0);
      // zero interval with the largest count fires on every tick
      queue_req(rtp_pkg::OP_START, 16'd0, 16'h0F0F, 8'hFF);
      // fill the rest of the pool, then two starts that must bounce
      for (int k = 0; k < 5; k++)
         queue_req(rtp_pkg::OP_START, 16'(4 + k), 16'(16'h0100 + k), 8'd0);
      queue_req(rtp_pkg::OP_START, 16'd5, 16'h7777, 8'd1);
      queue_req(rtp_pkg::OP_START, 16'd0, 16'h8888, 8'd0);
      repeat (6)
         queue_req(rtp_pkg::OP_TICK, 16'h00FF, 16'hFF00, 8'h0F);

      // sender pauses until everything predicted so far has come back
      do @(negedge clock);
      while (items_accepted != items_queued || expected_events.size() != 0);
      @(posedge clock);

      // random: mostly short timers with few repeats, now and then long
      // delays, large counts and random junk on ticks
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r.opcode = ($urandom_range(0, 99) < 42) ? rtp_pkg::OP_START : rtp_pkg::OP_TICK;
         r.tag    = TAG_W'($urandom);
         roll     = $urandom_range(0, 99);
         if (roll < 1)
            r.delay = DELAY_W'($urandom_range(0, 65535));
         else if (roll < 10)
            r.delay = DELAY_W'($urandom_range(7, 20));
         else
            r.delay = DELAY_W'($urandom_range(0, 6));
         roll = $urandom_range(0, 99);
         if (roll < 80)
            r.reps = REPS_W'($urandom_range(0, 3));
         else if (roll < 95)
            r.reps = REPS_W'($urandom_range(4, 15));
         else
            r.reps = REPS_W'($urandom_range(0, 255));
         pending_reqs.push_back(r);
         items_queued++;
      end

      // a stretch with no gaps on either side somewhere in the middle
      wait (items_accepted >= 200);
      quiet = 1'b1;
      wait (items_accepted >= 260);
      quiet = 1'b0;

      do @(negedge clock);
      while (items_accepted != items_queued || expected_events.size() != 0);
      // let a tick that is still sweeping finish, anything extra is caught
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d starts (%0d accepted, %0d rejected) and %0d ticks",
               starts_seen, accepts_seen, rejects_seen, ticks_seen);
      $display("with %0d expiry events checked, %0d mismatches", expiries_seen, errors);
      if (errors == 0 && expected_events.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[repeating_timer_pool.f]
sv/rtp_pkg.sv
sv/rtp_ctrl.sv
sv/rtp_datapath.sv
sv/repeating_timer_pool.sv
tb/tb_repeating_timer_pool.sv
